// File: rtl/crc4fr_pkg.sv
// Shared types, constants and CRC-4 helpers for the fragment reassembler.
package crc4fr_pkg;

    localparam int unsigned     JOB_QUEUE_DEPTH = 4;
    localparam logic [15:0]     TIMEOUT_RESET   = 16'd1000;
    localparam logic [4:0]      CRC_POLY        = 5'b10011;
    localparam logic [7:0]      DIV3_RECIP      = 8'd171;   // floor(x/3) = (x*171)>>9, x<256
    localparam logic [15:0]     IDLE_MAX        = 16'hFFFF;

    typedef enum logic [1:0] {
        KIND_BYTE        = 2'd0,
        KIND_SEQ_REJECT  = 2'd1,
        KIND_CRC_REJECT  = 2'd2,
        KIND_EMPTY_DONE  = 2'd3
    } kind_t;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_WORD = 1'b1
    } op_t;

    typedef struct packed {
        logic        op;
        logic [31:0] word;
    } in_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] payload_byte;
        logic [7:0] byte_index;
        logic       message_done;
        logic [7:0] message_size;
        logic       last;
    } out_item_t;

    // Work handed from the classifier to the result sequencer.
    typedef struct packed {
        kind_t           kind;
        logic [1:0]      count;      // payload bytes to emit for KIND_BYTE
        logic [2:0][7:0] bytes;      // bytes[0] goes out first
        logic [7:0]      start_idx;
        logic [7:0]      size;
        logic            done;       // last byte completes the message
    } job_t;

    // Bit-serial CRC, used only to build the parallel masks at elaboration.
    function automatic logic [3:0] crc4_serial(input logic [23:0] d);
        logic [27:0] r;
        r = {d, 4'b0000};
        for (int b = 27; b >= 4; b--) begin
            if (r[b]) begin
                r = r ^ (28'(CRC_POLY) << (b - 4));
            end
        end
        return r[3:0];
    endfunction

    function automatic logic [23:0] crc4_mask(input int j);
        logic [23:0] m;
        logic [3:0]  c;
        m = '0;
        for (int i = 0; i < 24; i++) begin
            c    = crc4_serial(24'(1) << i);
            m[i] = c[j];
        end
        return m;
    endfunction

    localparam logic [3:0][23:0] CRC_MASK = {crc4_mask(3), crc4_mask(2),
                                             crc4_mask(1), crc4_mask(0)};

    // Parallel CRC-4: each remainder bit is the parity of a fixed data subset.
    function automatic logic [3:0] crc4_fast(input logic [23:0] d);
        logic [3:0] c;
        for (int j = 0; j < 4; j++) begin
            c[j] = ^(d & CRC_MASK[j]);
        end
        return c;
    endfunction

endpackage

// File: rtl/crc4fr_queue.sv
// Small job queue between the classifier and the result sequencer.
module crc4fr_queue #(
    parameter int unsigned DEPTH = crc4fr_pkg::JOB_QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  crc4fr_pkg::job_t  push_job,
    output logic              full,
    input  logic              pop,
    output crc4fr_pkg::job_t  head_job,
    output logic              head_valid
);
    import crc4fr_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    job_t          slots_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = slots_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// File: rtl/crc4fr_front.sv
// Request classifier: timeout, sequence and CRC checks, reassembly state.
module crc4fr_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [15:0]          cfg_wr_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  crc4fr_pkg::in_item_t s_item,
    output logic                 job_push,
    output crc4fr_pkg::job_t     job,
    input  logic                 queue_full
);
    import crc4fr_pkg::*;

    logic [15:0] timeout_reg;
    logic [4:0]  expected_reg, expected_next;
    logic [6:0]  final_reg, final_next;
    logic [7:0]  received_reg, received_next;
    logic [7:0]  total_reg, total_next;
    logic [15:0] idle_reg, idle_next;

    logic        accept;
    logic        is_word;
    logic [3:0]  frag;
    logic [3:0]  crc_rx;
    logic [23:0] data;
    logic [4:0]  expected_eff;
    logic        seq_ok, crc_ok;
    logic [7:0]  size_in;
    logic [15:0] div_prod;
    logic [6:0]  final_new;
    logic [7:0]  total_new, recv_base, remaining, recv_after;
    logic [1:0]  nbytes, count;
    logic        done;

    assign s_ready  = !queue_full;
    assign accept   = s_valid && s_ready;
    assign is_word  = (s_item.op == OP_WORD);
    assign frag     = s_item.word[31:28];
    assign crc_rx   = s_item.word[27:24];
    assign data     = s_item.word[23:0];
    assign size_in  = data[23:16];
    assign div_prod = 16'(size_in) * 16'(DIV3_RECIP);

    always_comb begin
        expected_eff = (idle_reg >= timeout_reg) ? 5'd0 : expected_reg;
        seq_ok       = ({1'b0, frag} == expected_eff);
        crc_ok       = (crc4_fast(data) == crc_rx);

        if (frag == 4'd0) begin
            final_new = (size_in <= 8'd2) ? 7'd0 : div_prod[15:9];
            total_new = size_in;
            recv_base = 8'd0;
            nbytes    = 2'd2;
        end else begin
            final_new = final_reg;
            total_new = total_reg;
            recv_base = received_reg;
            nbytes    = 2'd3;
        end
        remaining  = total_new - recv_base;
        count      = (remaining >= 8'(nbytes)) ? nbytes : remaining[1:0];
        recv_after = recv_base + 8'(count);
        done       = (recv_after == total_new);
    end

    // State update and job record
    always_comb begin
        expected_next = expected_reg;
        final_next    = final_reg;
        received_next = received_reg;
        total_next    = total_reg;
        idle_next     = idle_reg;
        job_push      = 1'b0;
        job           = '0;
        job.kind      = KIND_BYTE;

        if (accept && !is_word) begin
            idle_next = (idle_reg == IDLE_MAX) ? idle_reg : idle_reg + 16'd1;
        end else if (accept) begin
            job_push      = 1'b1;
            expected_next = expected_eff;
            if (!seq_ok) begin
                job.kind = KIND_SEQ_REJECT;
            end else if (!crc_ok) begin
                job.kind = KIND_CRC_REJECT;
            end else begin
                final_next    = final_new;
                idle_next     = 16'd0;
                expected_next = ({3'b000, frag} == final_new) ? 5'd0
                                                             : {1'b0, frag} + 5'd1;
                received_next = done ? 8'd0 : recv_after;
                total_next    = done ? 8'd0 : total_new;
                job.kind      = (done && count == 2'd0) ? KIND_EMPTY_DONE : KIND_BYTE;
                job.count     = count;
                job.start_idx = recv_base;
                job.size      = total_new;
                job.done      = done;
                if (frag == 4'd0) begin
                    job.bytes = {8'd0, data[7:0], data[15:8]};
                end else begin
                    job.bytes = {data[7:0], data[15:8], data[23:16]};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg  <= TIMEOUT_RESET;
            expected_reg <= '0;
            final_reg    <= '0;
            received_reg <= '0;
            total_reg    <= '0;
            idle_reg     <= '0;
        end else begin
            if (cfg_wr_en) begin
                timeout_reg <= cfg_wr_data;
            end
            expected_reg <= expected_next;
            final_reg    <= final_next;
            received_reg <= received_next;
            total_reg    <= total_next;
            idle_reg     <= idle_next;
        end
    end

    a_recv_within_size: assert property (@(posedge aclk) disable iff (!aresetn)
        received_reg <= total_reg)
        else $error("bytes received exceed announced size");

    a_push_only_on_word: assert property (@(posedge aclk) disable iff (!aresetn)
        job_push |-> (accept && is_word))
        else $error("job pushed without an accepted word");

    a_reject_keeps_progress: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && is_word && (!seq_ok || !crc_ok)) |=>
            (received_reg == $past(received_reg) && total_reg == $past(total_reg)))
        else $error("rejected word changed reassembly progress");

endmodule

// File: rtl/crc4fr_back.sv
// Result sequencer: expands each job into one to three results.
module crc4fr_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  crc4fr_pkg::job_t      head_job,
    input  logic                  head_valid,
    output logic                  job_pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output crc4fr_pkg::out_item_t m_item
);
    import crc4fr_pkg::*;

    logic [1:0] step_reg, step_next;
    logic       m_valid_reg, m_valid_next;
    out_item_t  m_item_reg, m_item_next;
    logic       load;
    logic [1:0] last_step_idx;
    logic       last_step;

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // Load the output register when a job is waiting and the register is empty or being drained.
    assign load          = head_valid && (!m_valid_reg || m_ready);
    assign last_step_idx = (head_job.kind == KIND_BYTE) ? head_job.count - 2'd1 : 2'd0;
    assign last_step     = (step_reg == last_step_idx);
    assign job_pop       = load && last_step;

    always_comb begin
        m_item_next = '0;
        unique case (head_job.kind)
            KIND_BYTE: begin
                m_item_next.kind         = KIND_BYTE;
                m_item_next.payload_byte = head_job.bytes[step_reg];
                m_item_next.byte_index   = head_job.start_idx + 8'(step_reg);
                m_item_next.message_done = head_job.done && last_step;
                m_item_next.message_size = head_job.size;
                m_item_next.last         = last_step;
            end
            KIND_SEQ_REJECT, KIND_CRC_REJECT: begin
                m_item_next.kind = head_job.kind;
                m_item_next.last = 1'b1;
            end
            KIND_EMPTY_DONE: begin
                m_item_next.kind         = KIND_EMPTY_DONE;
                m_item_next.message_done = 1'b1;
                m_item_next.last         = 1'b1;
            end
            default: begin
                m_item_next = '0;
            end
        endcase
    end

    always_comb begin
        step_next    = step_reg;
        m_valid_next = m_valid_reg;
        if (load) begin
            step_next    = last_step ? 2'd0 : step_reg + 2'd1;
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_item_reg <= m_item_next;
        end
    end

    a_step_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        step_reg != 2'd3)
        else $error("result step out of range");

    a_pop_rewinds_step: assert property (@(posedge aclk) disable iff (!aresetn)
        job_pop |=> (step_reg == 2'd0))
        else $error("step not cleared after job retired");

    a_load_fills_output: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> (m_valid_reg && m_item_reg.last == $past(last_step)))
        else $error("output register not loaded with current step");

endmodule

// File: rtl/crc4_fragment_reassembler.sv
// Top level of the CRC-4 checked fragment reassembler.
// Requests (ticks and radio words) are taken one per cycle while the job queue has room; a
// tick produces no result, a word is checked and classified in the cycle it is accepted and
// leaves one job in the queue. The result sequencer drains one result per cycle while m_ready
// is high, so a word yields one to three results (one per emitted byte, or one for a reject
// or an empty-message completion); sustained throughput is set by that sequencer,
// with QUEUE_DEPTH jobs buffered between the two sides. With the queue and output register
// empty, a word's first result is held in the queue slot and then the output register before
// it is presented. The timeout register resets to 1000 and is written through cfg_wr_en.
module crc4_fragment_reassembler #(
    parameter int unsigned QUEUE_DEPTH = crc4fr_pkg::JOB_QUEUE_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [15:0]           cfg_wr_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  crc4fr_pkg::in_item_t  s_item,
    output logic                  m_valid,
    input  logic                  m_ready,
    output crc4fr_pkg::out_item_t m_item
);
    import crc4fr_pkg::*;

    logic job_push, queue_full, job_pop, head_valid;
    job_t push_job, head_job;

    crc4fr_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .job_push    (job_push),
        .job         (push_job),
        .queue_full  (queue_full)
    );

    crc4fr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (job_push),
        .push_job   (push_job),
        .full       (queue_full),
        .pop        (job_pop),
        .head_job   (head_job),
        .head_valid (head_valid)
    );

    crc4fr_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_job   (head_job),
        .head_valid (head_valid),
        .job_pop    (job_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item     (m_item)
    );

endmodule
